/* rtl/tbbs_pkg.sv */
// Shared types, widths and codes of the three-band biquad splitter.
package tbbs_pkg;

  // Sample and coefficient formats: samples Q1.(SAMPLE_WIDTH-1), coefficients Q2.(COEF_WIDTH-2).
  localparam int SAMPLE_WIDTH = 24;
  localparam int COEF_WIDTH   = 20;
  localparam int COEF_FRAC    = COEF_WIDTH - 2;
  localparam int NUM_SECTIONS = 3;

  // Feed-forward sum needs two extra bits, the accumulator two more.
  localparam int FF_W   = SAMPLE_WIDTH + 2;
  localparam int MULB_W = COEF_WIDTH + FF_W;
  localparam int MULA_W = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_W  = MULB_W + 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((NUM_SECTIONS * SAMPLE_WIDTH + 7) / 8) * 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3 * COEF_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [FF_W-1:0]         ff_t;

  // One band's coefficients, b0 in the lowest bits as on the write port.
  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] a2;
    logic signed [COEF_WIDTH-1:0] a1;
    logic signed [COEF_WIDTH-1:0] b0;
  } coef_t;

  // Events raised by a configuration write.
  typedef struct packed {
    logic [NUM_SECTIONS-1:0] clr_band;
  } cfg_evt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_COEFS  = 2'd0,
    REG_MID_COEFS  = 2'd1,
    REG_HIGH_COEFS = 2'd2,
    REG_ENABLE     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  // Band positions in the coefficient and result order.
  localparam int SEC_LOW  = 0;
  localparam int SEC_MID  = 1;
  localparam int SEC_HIGH = 2;

endpackage

/* rtl/tbbs_cfg.sv */
// Configuration registers: band coefficients and the enable bit.
module tbbs_cfg (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [tbbs_pkg::CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [tbbs_pkg::CFG_DATA_W-1:0]             cfg_data_i,
  output tbbs_pkg::coef_t [tbbs_pkg::NUM_SECTIONS-1:0] coef_o,
  output logic                                        enable_o,
  output tbbs_pkg::cfg_evt_t                          evt_o
);
  import tbbs_pkg::*;

  coef_t [NUM_SECTIONS-1:0] coef_q, coef_d;
  logic                     enable_q, enable_d;
  cfg_evt_t                 evt;

  // Decode the write; a coefficient write also clears that band's history.
  always_comb begin
    coef_d       = coef_q;
    enable_d     = enable_q;
    evt.clr_band = '0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_LOW_COEFS: begin
          coef_d[SEC_LOW]       = coef_t'(cfg_data_i);
          evt.clr_band[SEC_LOW] = 1'b1;
        end
        REG_MID_COEFS: begin
          coef_d[SEC_MID]       = coef_t'(cfg_data_i);
          evt.clr_band[SEC_MID] = 1'b1;
        end
        REG_HIGH_COEFS: begin
          coef_d[SEC_HIGH]       = coef_t'(cfg_data_i);
          evt.clr_band[SEC_HIGH] = 1'b1;
        end
        REG_ENABLE: begin
          enable_d = cfg_data_i[0];
        end
        default: begin
          enable_d = enable_q;
        end
      endcase
    end
  end

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= '0;
      enable_q <= 1'b0;
    end else begin
      coef_q   <= coef_d;
      enable_q <= enable_d;
    end
  end

  assign coef_o   = coef_q;
  assign enable_o = enable_q;
  assign evt_o    = evt;

endmodule

/* rtl/tbbs_band.sv */
// One second-order section: multiply-accumulate, rounding and saturation.
module tbbs_band (
  input  tbbs_pkg::coef_t   coef_i,
  input  tbbs_pkg::ff_t     ff_i,
  input  tbbs_pkg::sample_t y1_i,
  input  tbbs_pkg::sample_t y2_i,
  output tbbs_pkg::sample_t y_o
);
  import tbbs_pkg::*;

  localparam logic signed [ACC_W-1:0] SatHi   = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SatLo   = -SatHi - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] RndHalf = ACC_W'(64'sd1 <<< (COEF_FRAC - 1));

  logic signed [MULB_W-1:0] mul_b;
  logic signed [MULA_W-1:0] mul_a1;
  logic signed [MULA_W-1:0] mul_a2;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  scaled;

  // Three parallel products of the section.
  assign mul_b  = $signed(coef_i.b0) * ff_i;
  assign mul_a1 = $signed(coef_i.a1) * y1_i;
  assign mul_a2 = $signed(coef_i.a2) * y2_i;

  // Sum, add half an LSB, then drop the fraction with floor.
  assign acc    = ACC_W'(mul_b) - ACC_W'(mul_a1) - ACC_W'(mul_a2) + RndHalf;
  assign scaled = acc >>> COEF_FRAC;

  // Saturate to the sample range.
  always_comb begin
    if (scaled > SatHi) begin
      y_o = SatHi[SAMPLE_WIDTH-1:0];
    end else if (scaled < SatLo) begin
      y_o = SatLo[SAMPLE_WIDTH-1:0];
    end else begin
      y_o = scaled[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

/* rtl/three_band_biquad_splitter_top.sv */
// Top level of the three-band biquad splitter: stream handshake and filter history.
//
// Usage: each input beat carries one Q1.23 sample in s_axis_tdata_i and a
// command in s_axis_tuser_i (0 processes the sample, 1 clears all history).
// A processed sample yields one output beat holding the lowpass, bandpass and
// highpass results. Clear beats, and samples while the block is disabled,
// yield no output beat. Coefficients and the enable bit are loaded through
// the write port, by the user only while the block is idle (the block does
// not enforce this); a coefficient write clears that band's output history.
// An accepted input beat is held in the input register, then passes through
// the multiply-accumulate of all three sections into the output register.
// While the receiver takes beats, one beat per cycle is accepted, since each
// section's update feeds its own output history directly from its result.
// When the receiver stalls, the output register holds its beat and one more
// input beat waits in the input register before s_axis_tready_o drops.
// Reset clears the coefficients, the enable bit, all history and both
// register stages' valid flags.
module three_band_biquad_splitter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [tbbs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tbbs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [tbbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // sample_in
  input  logic                                s_axis_tuser_i,  // command
  // Output stream.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [tbbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o   // low_out, mid_out, high_out
);
  import tbbs_pkg::*;

  coef_t [NUM_SECTIONS-1:0] coef;
  logic                     enable;
  cfg_evt_t                 cfg_evt;

  logic    in_valid_q;
  cmd_e    in_cmd_q;
  sample_t in_sample_q;

  logic    out_valid_q;
  sample_t out_y_q [NUM_SECTIONS];

  sample_t x1_q, x2_q;
  sample_t y1_q [NUM_SECTIONS];
  sample_t y2_q [NUM_SECTIONS];

  ff_t     ff [NUM_SECTIONS];
  sample_t y_new [NUM_SECTIONS];

  logic out_free, produce, do_clear, advance;

  tbbs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef),
    .enable_o    (enable),
    .evt_o       (cfg_evt)
  );

  // Handshake: the held beat moves on unless it needs a busy output register.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign produce         = (in_cmd_q == CMD_SAMPLE) && enable;
  assign do_clear        = (in_cmd_q == CMD_CLEAR);
  assign advance         = in_valid_q && (!produce || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q    <= cmd_e'(s_axis_tuser_i);
      in_sample_q <= s_axis_tdata_i[SAMPLE_WIDTH-1:0];
    end
  end

  // Feed-forward sums shared from the input history.
  assign ff[SEC_LOW]  = FF_W'(in_sample_q) + (FF_W'(x1_q) <<< 1) + FF_W'(x2_q);
  assign ff[SEC_MID]  = FF_W'(in_sample_q) - FF_W'(x2_q);
  assign ff[SEC_HIGH] = FF_W'(in_sample_q) - (FF_W'(x1_q) <<< 1) + FF_W'(x2_q);

  // The three sections.
  for (genvar b = 0; b < NUM_SECTIONS; b++) begin : g_band
    tbbs_band u_band (
      .coef_i (coef[b]),
      .ff_i   (ff[b]),
      .y1_i   (y1_q[b]),
      .y2_i   (y2_q[b]),
      .y_o    (y_new[b])
    );
  end

  // Filter history: a clear beat clears all of it, a coefficient write that band's output history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        y1_q[b] <= '0;
        y2_q[b] <= '0;
      end
    end else begin
      if (advance && do_clear) begin
        x1_q <= '0;
        x2_q <= '0;
      end else if (advance && produce) begin
        x1_q <= in_sample_q;
        x2_q <= x1_q;
      end
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        if (cfg_evt.clr_band[b] || (advance && do_clear)) begin
          y1_q[b] <= '0;
          y2_q[b] <= '0;
        end else if (advance && produce) begin
          y1_q[b] <= y_new[b];
          y2_q[b] <= y1_q[b];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        out_y_q[b] <= y_new[b];
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_y_q[SEC_HIGH], out_y_q[SEC_MID],
                                         out_y_q[SEC_LOW]});

  // A waiting output beat is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |-> !(advance && produce))
    else $error("output beat overwritten while stalled");

  // A clear beat leaves all history at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && do_clear |=> x1_q == '0 && x2_q == '0 &&
      y1_q[SEC_LOW] == '0 && y1_q[SEC_MID] == '0 && y1_q[SEC_HIGH] == '0 &&
      y2_q[SEC_LOW] == '0 && y2_q[SEC_MID] == '0 && y2_q[SEC_HIGH] == '0)
    else $error("history not cleared by clear beat");

  // A low band coefficient write clears that band's output history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_evt.clr_band[SEC_LOW] |=> y1_q[SEC_LOW] == '0 && y2_q[SEC_LOW] == '0)
    else $error("low band history not cleared on coefficient write");

  // A processed sample raises an output beat and shifts into the input history.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && produce |=> out_valid_q && x1_q == $past(in_sample_q) &&
      y1_q[SEC_MID] == out_y_q[SEC_MID])
    else $error("sample result or history update lost");

endmodule

/* bench/tb_three_band_biquad_splitter_top.sv */
// Self-checking testbench of the three-band biquad splitter, with a bit-exact band predictor.
module tb_three_band_biquad_splitter_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tbbs_pkg::*;

  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned NUM_PHASES    = 12;

  // Coefficient sets used across the phases.
  typedef enum int {
    COEF_ZERO   = 0,
    COEF_MAX    = 1,
    COEF_MIN    = 2,
    COEF_RANDOM = 3,
    COEF_DAMPED = 4
  } coef_style_e;

  typedef logic [NUM_SECTIONS*SAMPLE_WIDTH-1:0] band_word_t;

  // Band predictor and the queue of band results still to arrive.
  class band_split_scoreboard;
    longint b0[NUM_SECTIONS];
    longint a1[NUM_SECTIONS];
    longint a2[NUM_SECTIONS];
    longint y1[NUM_SECTIONS];
    longint y2[NUM_SECTIONS];
    longint x1;
    longint x2;
    bit enabled;
    band_word_t pending_bands[$];
    int unsigned errors;
    string band_name[NUM_SECTIONS];

    function new();
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        b0[b] = 0;
        a1[b] = 0;
        a2[b] = 0;
        y1[b] = 0;
        y2[b] = 0;
      end
      x1 = 0;
      x2 = 0;
      enabled = 1'b0;
      errors = 0;
      band_name[SEC_LOW]  = "low_out";
      band_name[SEC_MID]  = "mid_out";
      band_name[SEC_HIGH] = "high_out";
    endfunction

    // A coefficient write loads the band and clears its output history only.
    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      coef_t c;
      int b;
      c = data;
      b = int'(idx);
      if (idx == REG_ENABLE) begin
        enabled = data[0];
      end else begin
        b0[b] = longint'($signed(c.b0));
        a1[b] = longint'($signed(c.a1));
        a2[b] = longint'($signed(c.a2));
        y1[b] = 0;
        y2[b] = 0;
      end
    endfunction

    // Round half up at the Q2.18 point, then saturate to the sample range.
    function longint round_sat(longint acc);
      longint v;
      v = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
      if (v > longint'(SMP_MAX)) return longint'(SMP_MAX);
      if (v < longint'(SMP_MIN)) return longint'(SMP_MIN);
      return v;
    endfunction

    function void note_input(cmd_e cmd, sample_t smp);
      longint x;
      longint acc;
      longint ff[NUM_SECTIONS];
      longint y[NUM_SECTIONS];
      band_word_t res;
      if (cmd == CMD_CLEAR) begin
        x1 = 0;
        x2 = 0;
        for (int b = 0; b < NUM_SECTIONS; b++) begin
          y1[b] = 0;
          y2[b] = 0;
        end
        return;
      end
      if (!enabled) return;
      x = longint'(smp);
      ff[SEC_LOW]  = x + 2 * x1 + x2;
      ff[SEC_MID]  = x - x2;
      ff[SEC_HIGH] = x - 2 * x1 + x2;
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        acc = b0[b] * ff[b] - a1[b] * y1[b] - a2[b] * y2[b];
        y[b] = round_sat(acc);
        res[b*SAMPLE_WIDTH +: SAMPLE_WIDTH] = y[b][SAMPLE_WIDTH-1:0];
      end
      x2 = x1;
      x1 = x;
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        y2[b] = y1[b];
        y1[b] = y[b];
      end
      pending_bands.push_back(res);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      band_word_t want;
      sample_t got_f;
      sample_t want_f;
      if (pending_bands.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%t: output beat %h with no result expected", $realtime, tdata);
        end
        return;
      end
      want = pending_bands.pop_front();
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        got_f  = tdata[b*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        want_f = want[b*SAMPLE_WIDTH +: SAMPLE_WIDTH];
        if (got_f !== want_f) begin
          errors++;
          if (errors <= 10) begin
            $display("%t: %s expected %0d actual %0d", $realtime, band_name[b], want_f, got_f);
          end
        end
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;   // sample_in
  logic                   s_axis_tuser_i = 1'b0; // command
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;        // low_out, mid_out, high_out

  band_split_scoreboard sb = new();
  bit burst_mode = 1'b0;
  int unsigned rx_hold_cycles = 0;

  three_band_biquad_splitter_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("tb_three_band_biquad_splitter_top: errors");
    $finish;
  end

  function automatic logic [CFG_DATA_W-1:0] pick_coefs(coef_style_e style);
    coef_t c;
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (style)
      COEF_ZERO: begin
        c = '0;
      end
      COEF_MAX: begin
        c = {NUM_SECTIONS{1'b0, {(COEF_WIDTH-1){1'b1}}}};
      end
      COEF_MIN: begin
        c = {NUM_SECTIONS{1'b1, {(COEF_WIDTH-1){1'b0}}}};
      end
      COEF_RANDOM: begin
        c = r[CFG_DATA_W-1:0];
      end
      default: begin
        // Small gain with a pole pair that mostly stays inside the unit circle.
        c.b0 = COEF_WIDTH'(int'($urandom_range(0, 1 << 15)) - (1 << 14));
        c.a1 = COEF_WIDTH'(-int'($urandom_range(0, 1 << 19)));
        c.a2 = COEF_WIDTH'($urandom_range(0, (1 << 18) - 1));
      end
    endcase
    return c;
  endfunction

  function automatic sample_t pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return sample_t'($urandom);
    if (r < 9) return sample_t'(int'($urandom_range(0, 8191)) - 4096);
    case ($urandom_range(0, 3))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return sample_t'(0);
      default: return sample_t'(-1);
    endcase
  endfunction

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Writes the selected bands, then the enable bit with random upper bits.
  task automatic configure(bit [NUM_SECTIONS-1:0] band_mask,
                           coef_style_e styles[NUM_SECTIONS], bit en);
    logic [63:0] r;
    r = {$urandom, $urandom};
    for (int b = 0; b < NUM_SECTIONS; b++) begin
      if (band_mask[b]) cfg_write(cfg_idx_e'(b), pick_coefs(styles[b]));
    end
    cfg_write(REG_ENABLE, {r[CFG_DATA_W-1:1], en});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_beat(cmd_e cmd, sample_t smp);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(cmd, smp);
  endtask

  task automatic send_random_beat();
    cmd_e cmd;
    cmd = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_SAMPLE;
    send_beat(cmd, pick_sample());
  endtask

  // Stops sending and waits for every outstanding band result, then lets the pipe settle.
  task automatic wait_idle();
    int unsigned n;
    n = 0;
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_bands.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Result side: random stalls, bursts with none, and one long hold-off on request.
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles != 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = burst_mode ? 0 : $urandom_range(0, 9);
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o);
    end
  end

  // Stimulus: directed corner cases, then random phases over several coefficient sets.
  initial begin
    coef_style_e styles[NUM_SECTIONS];
    bit [NUM_SECTIONS-1:0] band_mask;
    int unsigned n_items;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Samples while disabled after reset give nothing and leave the history alone.
    send_beat(CMD_SAMPLE, SMP_MAX);
    send_beat(CMD_SAMPLE, SMP_MIN);
    wait_idle();

    // Saturating lowpass, damped bandpass, most negative highpass.
    styles = '{COEF_MAX, COEF_DAMPED, COEF_MIN};
    configure('1, styles, 1'b1);
    send_beat(CMD_SAMPLE, SMP_MAX);
    send_beat(CMD_SAMPLE, SMP_MAX);
    send_beat(CMD_SAMPLE, SMP_MIN);
    send_beat(CMD_SAMPLE, SMP_MIN);
    send_beat(CMD_SAMPLE, sample_t'(0));
    send_beat(CMD_SAMPLE, sample_t'(-1));
    send_beat(CMD_SAMPLE, sample_t'(1));
    send_beat(CMD_CLEAR, SMP_MAX);
    send_beat(CMD_SAMPLE, SMP_MAX);
    send_beat(CMD_SAMPLE, sample_t'(0));
    send_beat(CMD_CLEAR, sample_t'(0));
    send_beat(CMD_CLEAR, SMP_MIN);
    send_beat(CMD_SAMPLE, SMP_MIN);
    send_beat(CMD_SAMPLE, sample_t'(12345));
    wait_idle();

    // Disable with random upper data bits, then a clear that still acts while disabled.
    configure('0, styles, 1'b0);
    send_beat(CMD_SAMPLE, SMP_MAX);
    send_beat(CMD_SAMPLE, sample_t'(-1));
    send_beat(CMD_CLEAR, SMP_MAX);
    wait_idle();
    configure('0, styles, 1'b1);
    send_beat(CMD_SAMPLE, sample_t'(1));
    send_beat(CMD_SAMPLE, SMP_MAX);
    wait_idle();

    // Rewriting the mid band alone keeps the input and the other bands' history.
    configure(3'b010, styles, 1'b1);
    send_beat(CMD_SAMPLE, SMP_MIN);
    send_beat(CMD_SAMPLE, sample_t'(-4096));
    send_beat(CMD_SAMPLE, SMP_MAX);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      burst_mode = 1'b0;
      band_mask = (p < 5) ? '1 : NUM_SECTIONS'($urandom_range(0, 7));
      for (int b = 0; b < NUM_SECTIONS; b++) begin
        styles[b] = (p < 5) ? coef_style_e'(p) : coef_style_e'($urandom_range(0, 4));
      end
      configure(band_mask, styles, p != 7);
      burst_mode = (p % 4 == 3) || (p == 6);
      // The receiver holds off while the sender keeps offering beats.
      if (p == 6) rx_hold_cycles = LONG_HOLD;
      n_items = (p == 7) ? 40 : 120;
      repeat (n_items) send_random_beat();
    end

    burst_mode = 1'b0;
    wait_idle();
    if (sb.pending_bands.size() != 0) begin
      $display("%0d band results never arrived", sb.pending_bands.size());
    end
    if (sb.errors == 0 && sb.pending_bands.size() == 0) begin
      $display("tb_three_band_biquad_splitter_top: clean");
    end else begin
      $display("tb_three_band_biquad_splitter_top: errors");
    end
    $finish;
  end

endmodule

/* three_band_biquad_splitter_top.f */
rtl/tbbs_pkg.sv
rtl/tbbs_cfg.sv
rtl/tbbs_band.sv
rtl/three_band_biquad_splitter_top.sv
bench/tb_three_band_biquad_splitter_top.sv
